/* design/bbe_pkg.sv */
// Shared types, constants and the reciprocal table of the 3x3 box blur.
`default_nettype none

package bbe_pkg;

  localparam int CH_W      = 8;
  localparam int FW_W      = 11;
  localparam int FH_W      = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET = 13'd768;

  localparam int RSUM_W      = 10;
  localparam int TSUM_W      = 12;
  localparam int SUM_W       = 13;
  localparam int CNT_W       = 4;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_W      = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic top_in;
    logic bot_in;
    logic left_in;
    logic right_in;
  } win_mask_t;

  typedef struct packed {
    rgb_t [2:0][2:0] pix;
    win_mask_t       mask;
    logic            last;
  } job_t;

  typedef struct packed {
    rgb_t px;
    logic frame_end;
  } result_t;

  // ceil(2^18 / (2*n)) for every neighbour count n that can occur
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    unique case (n)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* design/bbe_fifo.sv */
// Small register queue with occupancy count.
`default_nettype none

module bbe_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [W-1:0]               din,
  input  wire logic                       pop,
  output logic      [W-1:0]               dout,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign dout  = slots[head];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= wrap_inc(tail);
      end
      if (pop) begin
        head <= wrap_inc(head);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= din;
    end
  end

endmodule

`default_nettype wire

/* design/bbe_front.sv */
// Front end: configuration, position tracking, line store and 3x3 window.
`default_nettype none

module bbe_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int JQ_DEPTH  = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [bbe_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [bbe_pkg::CFG_W-1:0]             cfg_data,
  input  wire logic                                  push,
  input  wire logic                                  mode,
  input  wire bbe_pkg::rgb_t                         pix,
  input  wire logic [$clog2(JQ_DEPTH+1)-1:0]         jq_count,
  output logic                                       full,
  output logic                                       job_push,
  output bbe_pkg::job_t                              job
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CW  = (WW > bbe_pkg::FW_W) ? WW : bbe_pkg::FW_W;
  localparam int RW  = bbe_pkg::FH_W;
  localparam int QCW = $clog2(JQ_DEPTH + 1);

  typedef struct packed {
    bbe_pkg::rgb_t upper;
    bbe_pkg::rgb_t middle;
  } line_t;

  logic [bbe_pkg::FW_W-1:0] frame_width;
  logic [bbe_pkg::FH_W-1:0] frame_height;
  logic [RW-1:0]            in_row;
  logic [AW-1:0]            in_col;

  line_t                    line_mem [MAX_WIDTH];
  line_t                    rd;
  line_t                    fwd_data;
  logic                     fwd_hit;
  line_t                    eff;
  line_t                    wr_line;

  logic                     s1_valid;
  logic                     s1_emit;
  logic                     s1_last;
  bbe_pkg::win_mask_t       s1_mask;
  logic [AW-1:0]            s1_ci;
  bbe_pkg::rgb_t            s1_px;

  bbe_pkg::rgb_t [2:0][2:0] win;
  bbe_pkg::rgb_t [2:0][2:0] win_next;

  logic [CW-1:0]            fw_ext;
  logic [WW-1:0]            w_eff;
  logic [RW-1:0]            h_eff;
  logic [AW-1:0]            w_m1;
  logic [RW-1:0]            h_m1;
  logic [AW-1:0]            cc;
  logic [RW-1:0]            cr;
  logic [QCW:0]             occ;
  logic                     past;
  logic                     drain;
  logic                     accept;
  logic                     active;
  logic                     emit;
  logic                     last;
  logic                     col_wrap;
  bbe_pkg::win_mask_t       mask;

  always_comb begin
    fw_ext = CW'(frame_width);
    if (fw_ext == '0) begin
      w_eff = WW'(1);
    end else if (fw_ext > CW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_ext);
    end
    h_eff = (frame_height == '0) ? RW'(1) : frame_height;
    w_m1  = AW'(w_eff - WW'(1));
    h_m1  = h_eff - RW'(1);

    occ    = {1'b0, jq_count} + (QCW+1)'(s1_valid);
    full   = (occ >= (QCW+1)'(JQ_DEPTH));
    past   = (in_row >= h_eff);
    drain  = mode || past;
    accept = push && !full;
    active = accept && !(mode && !past);

    emit = (in_row >= RW'(2)) || ((in_row == RW'(1)) && (in_col != '0));
    cc   = (in_col == '0) ? w_m1 : in_col - AW'(1);
    cr   = (in_col == '0) ? in_row - RW'(2) : in_row - RW'(1);

    mask.top_in   = (cr != '0);
    mask.bot_in   = (cr < h_m1);
    mask.left_in  = (cc != '0);
    mask.right_in = (cc < w_m1);
    last          = emit && (cr == h_m1) && (cc == w_m1);
    col_wrap      = ((WW'(in_col) + WW'(1)) >= w_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bbe_pkg::FW_RESET;
      frame_height <= bbe_pkg::FH_RESET;
      in_row       <= '0;
      in_col       <= '0;
      s1_valid     <= 1'b0;
      fwd_hit      <= 1'b0;
    end else begin
      s1_valid <= active;
      fwd_hit  <= s1_valid && active && (s1_ci == in_col);
      if (cfg_write) begin
        unique case (cfg_index)
          bbe_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[bbe_pkg::FW_W-1:0];
          bbe_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[bbe_pkg::FH_W-1:0];
          default: ;
        endcase
        in_row <= '0;
        in_col <= '0;
      end else if (active) begin
        if (last) begin
          in_row <= '0;
          in_col <= '0;
        end else if (col_wrap) begin
          in_col <= '0;
          in_row <= in_row + RW'(1);
        end else begin
          in_col <= in_col + AW'(1);
        end
      end
    end
  end

  // bypass the line written on the same edge as this read
  assign eff     = fwd_hit ? fwd_data : rd;
  assign wr_line = '{upper: eff.middle, middle: s1_px};

  always_ff @(posedge clk) begin
    if (active) begin
      rd      <= line_mem[in_col];
      s1_ci   <= in_col;
      s1_px   <= drain ? '0 : pix;
      s1_emit <= emit;
      s1_last <= last;
      s1_mask <= mask;
    end
    if (s1_valid) begin
      line_mem[s1_ci] <= wr_line;
      fwd_data        <= wr_line;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = eff.upper;
    win_next[1][2] = eff.middle;
    win_next[2][2] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      win <= '0;
    end else if (s1_valid) begin
      win <= s1_last ? '0 : win_next;
    end
  end

  assign job_push = s1_valid && s1_emit;
  assign job      = '{pix: win_next, mask: s1_mask, last: s1_last};

endmodule

`default_nettype wire

/* design/bbe_back.sv */
// Back end: masked window sums, neighbour count and rounded mean per channel.
`default_nettype none

module bbe_back #(
  parameter int OQ_DEPTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              jq_empty,
  input  wire bbe_pkg::job_t                     job,
  input  wire logic [$clog2(OQ_DEPTH+1)-1:0]     oq_count,
  output logic                                   jq_pop,
  output logic                                   res_push,
  output bbe_pkg::result_t                       res
);

  localparam int OCW = $clog2(OQ_DEPTH + 1);

  logic                                   b1_valid;
  logic                                   b2_valid;
  logic                                   b3_valid;
  logic [2:0][2:0][bbe_pkg::RSUM_W-1:0]   b1_rs;
  logic [bbe_pkg::CNT_W-1:0]              b1_n;
  logic                                   b1_last;
  logic [2:0][bbe_pkg::SUM_W-1:0]         b2_x;
  logic [bbe_pkg::RECIP_W-1:0]            b2_m;
  logic                                   b2_last;
  logic [2:0][bbe_pkg::PROD_W-1:0]        b3_prod;
  logic                                   b3_last;

  logic [OCW+1:0]                         occ;
  logic                                   take;
  logic [2:0]                             row_ok;
  logic [2:0]                             col_ok;
  logic [2:0][2:0][bbe_pkg::RSUM_W-1:0]   rs;
  logic [bbe_pkg::CNT_W-1:0]              n;
  logic [2:0][bbe_pkg::SUM_W-1:0]         x;
  logic [2:0][bbe_pkg::CH_W-1:0]          v;
  logic [bbe_pkg::TSUM_W-1:0]             t;

  always_comb begin
    occ  = (OCW+2)'(oq_count) + (OCW+2)'(b1_valid) + (OCW+2)'(b2_valid)
         + (OCW+2)'(b3_valid);
    take = !jq_empty && (occ < (OCW+2)'(OQ_DEPTH));

    row_ok = {job.mask.bot_in, 1'b1, job.mask.top_in};
    col_ok = {job.mask.right_in, 1'b1, job.mask.left_in};
    rs     = '0;
    v      = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        v = job.pix[r][c];
        for (int ch = 0; ch < 3; ch++) begin
          if (row_ok[r] && col_ok[c]) begin
            rs[ch][r] = rs[ch][r] + bbe_pkg::RSUM_W'(v[ch]);
          end
        end
      end
    end
    n = bbe_pkg::CNT_W'((2'd1 + 2'(job.mask.top_in) + 2'(job.mask.bot_in))
                      * (2'd1 + 2'(job.mask.left_in) + 2'(job.mask.right_in)));

    t = '0;
    for (int ch = 0; ch < 3; ch++) begin
      t     = bbe_pkg::TSUM_W'(b1_rs[ch][0]) + bbe_pkg::TSUM_W'(b1_rs[ch][1])
            + bbe_pkg::TSUM_W'(b1_rs[ch][2]);
      x[ch] = {t, 1'b0} + bbe_pkg::SUM_W'(b1_n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
    end else begin
      b1_valid <= take;
      b2_valid <= b1_valid;
      b3_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    b1_rs   <= rs;
    b1_n    <= n;
    b1_last <= job.last;
    b2_x    <= x;
    b2_m    <= bbe_pkg::recip(b1_n);
    b2_last <= b1_last;
    for (int ch = 0; ch < 3; ch++) begin
      b3_prod[ch] <= bbe_pkg::PROD_W'(b2_x[ch]) * bbe_pkg::PROD_W'(b2_m);
    end
    b3_last <= b2_last;
  end

  localparam int QL = bbe_pkg::RECIP_SHIFT;
  localparam int QH = bbe_pkg::RECIP_SHIFT + bbe_pkg::CH_W - 1;

  assign jq_pop       = take;
  assign res_push     = b3_valid;
  assign res.px.red   = b3_prod[2][QH:QL];
  assign res.px.green = b3_prod[1][QH:QL];
  assign res.px.blue  = b3_prod[0][QH:QL];
  assign res.frame_end = b3_last;

endmodule

`default_nettype wire

/* design/box_blur_3x3_edge_clipped.sv */
// Top level of the edge-clipped 3x3 RGB box blur.
//
// Pixels enter in raster order at up to one per clock, and results leave at
// up to one per clock; the sustained rate is one item per cycle while full
// stays low. The result for pixel k comes out on the (k+W+1)-th item, so a
// frame is followed by W+1 drain items; a drain item before the frame's last
// pixel is dropped. A pixel passes a line store read, the window stage, a
// four-entry job queue and a three-stage sum, count and reciprocal multiply
// before its result can be taken. Each output channel is the in-frame
// neighbour mean rounded half up. Any configuration write restarts the frame.
`default_nettype none

module box_blur_3x3_edge_clipped #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [bbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bbe_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              mode,
  input  wire logic [bbe_pkg::CH_W-1:0]          in_red,
  input  wire logic [bbe_pkg::CH_W-1:0]          in_green,
  input  wire logic [bbe_pkg::CH_W-1:0]          in_blue,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [bbe_pkg::CH_W-1:0]               out_red,
  output logic [bbe_pkg::CH_W-1:0]               out_green,
  output logic [bbe_pkg::CH_W-1:0]               out_blue,
  output logic                                   frame_end
);

  localparam int JQ_DEPTH = 4;
  localparam int OQ_DEPTH = 8;
  localparam int JW       = $bits(bbe_pkg::job_t);
  localparam int RESW     = $bits(bbe_pkg::result_t);

  bbe_pkg::rgb_t                    pix;
  bbe_pkg::job_t                    job_in;
  bbe_pkg::job_t                    job_out;
  bbe_pkg::result_t                 res_in;
  bbe_pkg::result_t                 res_out;
  logic [JW-1:0]                    jq_dout;
  logic [RESW-1:0]                  oq_dout;
  logic                             job_push;
  logic                             jq_pop;
  logic                             jq_empty;
  logic [$clog2(JQ_DEPTH+1)-1:0]    jq_count;
  logic                             res_push;
  logic [$clog2(OQ_DEPTH+1)-1:0]    oq_count;
  logic                             oq_pop;

  assign pix     = '{red: in_red, green: in_green, blue: in_blue};
  assign job_out = bbe_pkg::job_t'(jq_dout);
  assign res_out = bbe_pkg::result_t'(oq_dout);
  assign oq_pop  = pop && !empty;

  bbe_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .JQ_DEPTH  (JQ_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .mode      (mode),
    .pix       (pix),
    .jq_count  (jq_count),
    .full      (full),
    .job_push  (job_push),
    .job       (job_in)
  );

  bbe_fifo #(
    .W     (JW),
    .DEPTH (JQ_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (JW'(job_in)),
    .pop   (jq_pop),
    .dout  (jq_dout),
    .empty (jq_empty),
    .count (jq_count)
  );

  bbe_back #(
    .OQ_DEPTH (OQ_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .jq_empty (jq_empty),
    .job      (job_out),
    .oq_count (oq_count),
    .jq_pop   (jq_pop),
    .res_push (res_push),
    .res      (res_in)
  );

  bbe_fifo #(
    .W     (RESW),
    .DEPTH (OQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (RESW'(res_in)),
    .pop   (oq_pop),
    .dout  (oq_dout),
    .empty (empty),
    .count (oq_count)
  );

  assign out_red   = res_out.px.red;
  assign out_green = res_out.px.green;
  assign out_blue  = res_out.px.blue;
  assign frame_end = res_out.frame_end;

endmodule

`default_nettype wire

/* verif/box_blur_3x3_edge_clipped_tb.sv */
// Self-checking testbench for the edge-clipped 3x3 RGB box blur: directed table, random and extreme frames.
module box_blur_3x3_edge_clipped_tb;
  import bbe_pkg::*;

  localparam int LINE_MAX      = 1024;
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES   = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 550;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum logic [1:0] {
    ROW_PIXEL,
    ROW_DRAIN,
    ROW_SET_WIDTH,
    ROW_SET_HEIGHT
  } row_kind_t;

  typedef enum logic [1:0] {
    STEP_IGNORED,
    STEP_HELD,
    STEP_EMITTED
  } step_kind_t;

  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_HALF,
    POP_SPARSE,
    POP_MOSTLY
  } pop_style_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [12:0] value;
    rgb_t        px;
    logic        typed;
    logic        has_exp;
    result_t     exp;
  } dir_row_t;

  localparam result_t NO_RESULT = '0;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  reg_idx_t          cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              push = 1'b0;
  logic              full;
  logic              mode = 1'b0;
  logic [CH_W-1:0]   in_red = '0;
  logic [CH_W-1:0]   in_green = '0;
  logic [CH_W-1:0]   in_blue = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [CH_W-1:0]   out_red;
  logic [CH_W-1:0]   out_green;
  logic [CH_W-1:0]   out_blue;
  logic              frame_end;

  box_blur_3x3_edge_clipped #(.MAX_WIDTH(LINE_MAX)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .empty     (empty),
    .pop       (pop),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .frame_end (frame_end)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // blur model state
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  rgb_t            upper_line [LINE_MAX];
  rgb_t            middle_line [LINE_MAX];
  rgb_t            nbhd [3][3];
  int unsigned     row_cnt;
  int unsigned     col_cnt;
  int unsigned     pos_in;
  int unsigned     pos_out;

  result_t blurred_q [$];
  result_t want;
  int      mismatches = 0;
  int      fed_items = 0;
  int      burst_left = 0;
  int      hold_requests = 0;
  int      holds_taken = 0;
  int      hold_left = 0;
  int      pop_phase = 0;
  pop_style_t pop_style = POP_ALWAYS;
  int      cycles_run = 0;

  dir_row_t dir_rows [31] = '{
    '{ROW_SET_WIDTH,  13'd1, 24'h000000, 1'b1, 1'b0, NO_RESULT},
    '{ROW_SET_HEIGHT, 13'd1, 24'h000000, 1'b1, 1'b0, NO_RESULT},
    '{ROW_PIXEL,      13'd0, 24'hFFFFFF, 1'b1, 1'b0, NO_RESULT},
    '{ROW_DRAIN,      13'd0, 24'h000000, 1'b1, 1'b0, NO_RESULT},
    '{ROW_DRAIN,      13'd0, 24'h000000, 1'b1, 1'b1, {24'hFFFFFF, 1'b1}},
    '{ROW_DRAIN,      13'd0, 24'hFFFFFF, 1'b1, 1'b0, NO_RESULT},
    '{ROW_PIXEL,      13'd0, 24'h000000, 1'b1, 1'b0, NO_RESULT},
    '{ROW_PIXEL,      13'd0, 24'hFFFFFF, 1'b1, 1'b0, NO_RESULT},
    '{ROW_DRAIN,      13'd0, 24'h000000, 1'b1, 1'b1, {24'h000000, 1'b1}},
    '{ROW_SET_WIDTH,  13'd0, 24'h000000, 1'b1, 1'b0, NO_RESULT},
    '{ROW_SET_HEIGHT, 13'd0, 24'h000000, 1'b1, 1'b0, NO_RESULT},
    '{ROW_PIXEL,      13'd0, 24'h010203, 1'b1, 1'b0, NO_RESULT},
    '{ROW_DRAIN,      13'd0, 24'h000000, 1'b1, 1'b0, NO_RESULT},
    '{ROW_DRAIN,      13'd0, 24'h000000, 1'b1, 1'b1, {24'h010203, 1'b1}},
    '{ROW_SET_WIDTH,  13'd2, 24'h000000, 1'b1, 1'b0, NO_RESULT},
    '{ROW_SET_HEIGHT, 13'd2, 24'h000000, 1'b1, 1'b0, NO_RESULT},
    '{ROW_PIXEL,      13'd0, 24'h0201FF, 1'b1, 1'b0, NO_RESULT},
    '{ROW_PIXEL,      13'd0, 24'h000000, 1'b1, 1'b0, NO_RESULT},
    '{ROW_DRAIN,      13'd0, 24'h000000, 1'b1, 1'b0, NO_RESULT},
    '{ROW_PIXEL,      13'd0, 24'h000000, 1'b1, 1'b0, NO_RESULT},
    '{ROW_PIXEL,      13'd0, 24'h000000, 1'b1, 1'b1, {24'h010040, 1'b0}},
    '{ROW_DRAIN,      13'd0, 24'h000000, 1'b1, 1'b1, {24'h010040, 1'b0}},
    '{ROW_DRAIN,      13'd0, 24'h000000, 1'b1, 1'b1, {24'h010040, 1'b0}},
    '{ROW_DRAIN,      13'd0, 24'h000000, 1'b1, 1'b1, {24'h010040, 1'b1}},
    '{ROW_PIXEL,      13'd0, 24'h80FF7F, 1'b0, 1'b0, NO_RESULT},
    '{ROW_PIXEL,      13'd0, 24'h7F0080, 1'b0, 1'b0, NO_RESULT},
    '{ROW_PIXEL,      13'd0, 24'h123456, 1'b0, 1'b0, NO_RESULT},
    '{ROW_PIXEL,      13'd0, 24'hFEDCBA, 1'b0, 1'b0, NO_RESULT},
    '{ROW_DRAIN,      13'd0, 24'h000000, 1'b0, 1'b0, NO_RESULT},
    '{ROW_DRAIN,      13'd0, 24'h000000, 1'b0, 1'b0, NO_RESULT},
    '{ROW_DRAIN,      13'd0, 24'h000000, 1'b0, 1'b0, NO_RESULT}
  };

  function automatic void rewind_frame();
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        nbhd[r][c] = '0;
    row_cnt = 0;
    col_cnt = 0;
    pos_in  = 0;
    pos_out = 0;
  endfunction

  function automatic step_kind_t blur_advance(input logic drain_mode, input rgb_t px_in,
                                              output result_t res);
    int unsigned w, h, total, col, cc, cr, cnt;
    int unsigned sum_r, sum_g, sum_b;
    logic        drain, emitted, last;
    rgb_t        px;
    res = '0;
    w = (width_reg == 0) ? 1 : (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
    h = (height_reg == 0) ? 1 : height_reg;
    total = w * h;
    drain = drain_mode || pos_in >= total;
    if (drain && pos_in < total) return STEP_IGNORED;
    px = drain ? rgb_t'('0) : px_in;
    col = col_cnt % LINE_MAX;
    for (int r = 0; r < 3; r++) begin
      nbhd[r][0] = nbhd[r][1];
      nbhd[r][1] = nbhd[r][2];
    end
    nbhd[0][2] = upper_line[col];
    nbhd[1][2] = middle_line[col];
    nbhd[2][2] = px;
    upper_line[col] = middle_line[col];
    middle_line[col] = px;
    emitted = pos_in >= w + 1;
    last = 1'b0;
    if (emitted) begin
      cc = (col_cnt == 0) ? w - 1 : col_cnt - 1;
      cr = (col_cnt == 0) ? row_cnt - 2 : row_cnt - 1;
      last = (cr == h - 1) && (cc == w - 1);
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      cnt = 0;
      for (int r = 0; r < 3; r++) begin
        if (r == 0 && cr == 0) continue;
        if (r == 2 && cr + 1 >= h) continue;
        for (int c = 0; c < 3; c++) begin
          if (c == 0 && cc == 0) continue;
          if (c == 2 && cc + 1 >= w) continue;
          sum_r += nbhd[r][c].red;
          sum_g += nbhd[r][c].green;
          sum_b += nbhd[r][c].blue;
          cnt++;
        end
      end
      res.px.red   = 8'((2 * sum_r + cnt) / (2 * cnt));
      res.px.green = 8'((2 * sum_g + cnt) / (2 * cnt));
      res.px.blue  = 8'((2 * sum_b + cnt) / (2 * cnt));
      res.frame_end = last;
      if (last) begin
        rewind_frame();
        return STEP_EMITTED;
      end
      pos_out++;
    end
    pos_in++;
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    return emitted ? STEP_EMITTED : STEP_HELD;
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic rgb_t random_rgb();
    rgb_t px;
    px.red   = pick_level();
    px.green = pick_level();
    px.blue  = pick_level();
    return px;
  endfunction

  // hold push low until every expected result has been checked, then let the pipe settle
  task automatic wait_drained(input int settle);
    push <= 1'b0;
    do @(posedge clk); while (blurred_q.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [12:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  width_reg = val[FW_W-1:0];
      REG_FRAME_HEIGHT: height_reg = val;
      default: ;
    endcase
    rewind_frame();
  endtask

  task automatic reconfigure(input logic [12:0] width_raw, input logic [12:0] height_raw);
    logic height_first;
    height_first = $urandom_range(0, 1);
    wait_drained(SETTLE_CYCLES);
    write_reg(height_first ? REG_FRAME_HEIGHT : REG_FRAME_WIDTH,
              height_first ? height_raw : width_raw);
    wait_drained(SETTLE_CYCLES);
    write_reg(height_first ? REG_FRAME_WIDTH : REG_FRAME_HEIGHT,
              height_first ? width_raw : height_raw);
  endtask

  task automatic send_item(input logic drain_mode, input rgb_t px, input logic typed = 1'b0,
                           input logic typed_has = 1'b0, input result_t typed_exp = '0);
    step_kind_t status;
    result_t    predicted;
    int         gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 6);
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push     <= 1'b1;
    mode     <= drain_mode;
    in_red   <= px.red;
    in_green <= px.green;
    in_blue  <= px.blue;
    do @(posedge clk); while (full);
    status = blur_advance(drain_mode, px, predicted);
    if (status != STEP_IGNORED) fed_items++;
    if (typed) begin
      if (typed_has) blurred_q.push_back(typed_exp);
    end else if (status == STEP_EMITTED) begin
      blurred_q.push_back(predicted);
    end
  endtask

  // w, h are the effective sizes; fewer than w*h pixels leaves the frame open
  task automatic send_frame(input int w, input int h, input int pixels);
    int pause_at;
    pause_at = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, pixels - 1)) : -1;
    for (int i = 0; i < pixels; i++) begin
      if (i == pause_at) wait_drained(0);
      if ($urandom_range(0, 11) == 0) send_item(1'b1, random_rgb());
      send_item(1'b0, random_rgb());
    end
    if (pixels == w * h) begin
      for (int i = 0; i <= w; i++) send_item($urandom_range(0, 3) != 0, random_rgb());
      if ($urandom_range(0, 7) == 0) send_item(1'b1, random_rgb());
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (blurred_q.size() == 0) begin
          $error("result with nothing expected: red %0d green %0d blue %0d frame_end %0b",
                 out_red, out_green, out_blue, frame_end);
          mismatches++;
        end else begin
          want = blurred_q.pop_front();
          if (out_red !== want.px.red) begin
            $error("out_red: expected %0d, got %0d", want.px.red, out_red);
            mismatches++;
          end
          if (out_green !== want.px.green) begin
            $error("out_green: expected %0d, got %0d", want.px.green, out_green);
            mismatches++;
          end
          if (out_blue !== want.px.blue) begin
            $error("out_blue: expected %0d, got %0d", want.px.blue, out_blue);
            mismatches++;
          end
          if (frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
            mismatches++;
          end
        end
      end
      if (hold_left == 0 && holds_taken != hold_requests && !empty) begin
        holds_taken = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (pop_phase == 0) begin
        pop_style = pop_style_t'($urandom_range(0, 3));
        pop_phase = $urandom_range(16, 80);
      end
      pop_phase--;
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (pop_style)
          POP_ALWAYS: pop <= 1'b1;
          POP_HALF:   pop <= $urandom_range(0, 1);
          POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
          default:    pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    dir_row_t row;
    int       w, h, frames;
    width_reg = FW_RESET;
    height_reg = FH_RESET;
    for (int i = 0; i < LINE_MAX; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    rewind_frame();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      case (row.kind)
        ROW_SET_WIDTH: begin
          wait_drained(SETTLE_CYCLES);
          write_reg(REG_FRAME_WIDTH, row.value);
        end
        ROW_SET_HEIGHT: begin
          wait_drained(SETTLE_CYCLES);
          write_reg(REG_FRAME_HEIGHT, row.value);
        end
        default: send_item(row.kind == ROW_DRAIN, row.px, row.typed, row.has_exp, row.exp);
      endcase
    end

    fed_items = 0;
    while (fed_items < RANDOM_ITEMS) begin
      w = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 16 : 5);
      h = $urandom_range(1, 5);
      reconfigure({2'($urandom_range(0, 3)), 11'((w == 1 && $urandom_range(0, 1)) ? 0 : w)},
                  13'((h == 1 && $urandom_range(0, 1)) ? 0 : h));
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++)
        send_frame(w, h, (f == frames - 1 && $urandom_range(0, 5) == 0) ?
                   int'($urandom_range(1, w * h)) : w * h);
    end

    // widest line: the receiver holds off once results start, so the input backs up
    reconfigure(13'h1FFF, 13'd1);
    hold_requests++;
    send_frame(LINE_MAX, 1, LINE_MAX);
    reconfigure(13'd1024, 13'd2);
    send_frame(LINE_MAX, 2, LINE_MAX + 6);
    reconfigure(13'd3, 13'd4096);
    send_frame(3, 4096, 25);
    reconfigure(13'd1, 13'h1FFF);
    send_frame(1, 8191, 20);
    reconfigure(13'd4, 13'd3);
    send_frame(4, 3, 12);

    wait_drained(TAIL_CYCLES);
    if (mismatches == 0 && blurred_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
